[hdl/olpt_pkg.sv]
// Shared types and constants for the ordered list position table.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package olpt_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;

   // Controller to datapath: run one operation this cycle.
   typedef struct packed {
      logic execute;
   } olpt_cmd_type;

endpackage

`default_nettype wire

[hdl/olpt_channels.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on olpt_pkg for field widths.
`default_nettype none

interface olpt_req_if;
   import olpt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [POS_W-1:0]       position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

interface olpt_rsp_if;
   import olpt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic [STATUS_W-1:0]      status;
   logic [LEN_W-1:0]         length;

   modport source (output valid, output read_value, output status, output length,
                   input ready);
   modport sink   (input valid, input read_value, input status, input length,
                   output ready);
endinterface

`default_nettype wire

[hdl/olpt_ctrl.sv]
// Handshake controller: tracks whether a response is held and issues execute.
// Depends on olpt_pkg for the command struct.
`default_nettype none

module olpt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output olpt_pkg::olpt_cmd_type    cmd
);
   import olpt_pkg::*;

   localparam logic ST_EMPTY = 1'b0;
   localparam logic ST_HELD  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // Take a new transaction when the result slot is empty or being drained.
   assign req_ready   = (state_ff == ST_EMPTY) || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = (state_ff == ST_HELD);
   assign cmd.execute = accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_HELD;
         end
         ST_HELD: begin
            if (accept)         state_in = ST_HELD;
            else if (rsp_ready) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no response");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !accept) |=> !rsp_valid)
      else $error("response repeated after it was taken");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result slot");
`endif

endmodule

`default_nettype wire

[hdl/olpt_datapath.sv]
// Datapath: chain of list cells, entry count, operation checks, result register.
// Depends on olpt_pkg for codes, widths and the command struct.
`default_nettype none

module olpt_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire olpt_pkg::olpt_cmd_type               cmd,
   input  wire logic [olpt_pkg::OP_W-1:0]            operation,
   input  wire logic [olpt_pkg::POS_W-1:0]           position,
   input  wire logic signed [olpt_pkg::DATA_W-1:0]   value,
   output logic signed [olpt_pkg::DATA_W-1:0]        read_value,
   output logic [olpt_pkg::STATUS_W-1:0]             status,
   output logic [olpt_pkg::LEN_W-1:0]                length
);
   import olpt_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   data_type               cell_ff [CAPACITY];
   data_type               cell_in [CAPACITY];
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   data_type               read_value_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [LEN_W-1:0]       length_ff;

   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       cnt_ext;
   logic [STATUS_W-1:0]    status_now;
   logic                   insert_go;
   logic                   remove_go;
   data_type               cell_sel;
   data_type               read_now;

   assign pos_ext = CMP_W'(position);
   assign cnt_ext = CMP_W'(count_ff);

   always_comb begin
      status_now = STATUS_OK;
      case (operation)
         OP_INSERT: begin
            if (pos_ext > cnt_ext)                   status_now = STATUS_RANGE;
            else if (cnt_ext >= CMP_W'(CAPACITY))    status_now = STATUS_FULL;
         end
         OP_REMOVE, OP_READ: begin
            if (pos_ext >= cnt_ext) status_now = STATUS_RANGE;
         end
         default: status_now = STATUS_OK;
      endcase
   end

   assign insert_go = cmd.execute && (operation == OP_INSERT) && (status_now == STATUS_OK);
   assign remove_go = cmd.execute && (operation == OP_REMOVE) && (status_now == STATUS_OK);

   // Each cell loads, shifts toward the tail, shifts toward the head, or holds.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      data_type from_head;
      data_type from_tail;

      if (g == 0) begin : g_first
         assign from_head = cell_ff[g];
      end else begin : g_rest
         assign from_head = cell_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign from_tail = cell_ff[g];
      end else begin : g_body
         assign from_tail = cell_ff[g+1];
      end

      always_comb begin
         cell_in[g] = cell_ff[g];
         if (insert_go) begin
            if (CMP_W'(g) == pos_ext)     cell_in[g] = value;
            else if (CMP_W'(g) > pos_ext) cell_in[g] = from_head;
         end else if (remove_go) begin
            if (CMP_W'(g) >= pos_ext) cell_in[g] = from_tail;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[g] <= cell_in[g];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (insert_go)                                          count_in = count_ff + CNT_W'(1);
      else if (remove_go)                                     count_in = count_ff - CNT_W'(1);
      else if (cmd.execute && (operation == OP_CLEAR))        count_in = '0;
   end

   assign cell_sel = cell_ff[ADDR_W'(pos_ext)];
   assign read_now = ((operation == OP_READ) && (status_now == STATUS_OK)) ? cell_sel : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         read_value_ff <= read_now;
         status_ff     <= status_now;
         length_ff     <= LEN_W'(count_in);
      end
   end

   assign read_value = read_value_ff;
   assign status     = status_ff;
   assign length     = length_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      insert_go |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("successful insert did not grow the list");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && (operation == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries in the list");
`endif

endmodule

`default_nettype wire

[hdl/ordered_list_position_table_core.sv]
// Ordered list position table. Holds up to CAPACITY signed 32-bit entries in a
// chain of registers plus an entry count. Each request transaction carries an
// operation (insert, remove, read, clear), a position and a value; each yields
// exactly one response transaction with the read value (zero unless a read
// succeeds), a status (ok, position out of range, list full) and the length
// after the operation, modulo 32. In every operation all cells shift, hold or
// load at once, so a request can be accepted every cycle while the consumer
// keeps taking responses. The response sits in an output register in the
// cycle after acceptance, and a new request is taken in the same cycle that
// the held response is taken. Rejected operations leave the list unchanged.
// Entries are not cleared at reset; only the count is.
// Depends on olpt_pkg, the channel interfaces, olpt_ctrl and olpt_datapath.
`default_nettype none

module ordered_list_position_table_core #(
   parameter int CAPACITY = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   olpt_req_if.sink     req_bus,
   olpt_rsp_if.source   rsp_bus
);
   import olpt_pkg::*;

   olpt_cmd_type cmd;

   // Handshake control: hold the response until taken, issue execute on accept.
   olpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Cell chain, count and result register.
   olpt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .operation  (req_bus.operation),
      .position   (req_bus.position),
      .value      (req_bus.value),
      .read_value (rsp_bus.read_value),
      .status     (rsp_bus.status),
      .length     (rsp_bus.length)
   );

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for ordered_list_position_table_core: random and directed list operations
// with a shadow list that predicts every response transaction.
// Depends on olpt_pkg, the olpt_req_if/olpt_rsp_if interfaces and the core itself.
`default_nettype none

module tb;
   import olpt_pkg::*;

   localparam int LIST_CAPACITY    = 16;
   localparam int RANDOM_REQUESTS  = 750;
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 4;

   typedef struct {
      logic [OP_W-1:0]  operation;
      logic [POS_W-1:0] position;
      data_type         value;
      bit               drain_first;   // hold this request until the pipe is empty
   } list_request_type;

   typedef struct {
      data_type            read_value;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } list_response_type;

   logic clock;
   logic reset;

   olpt_req_if req_if ();
   olpt_rsp_if rsp_if ();

   ordered_list_position_table_core #(
      .CAPACITY (LIST_CAPACITY)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Requests waiting to be offered, and responses predicted but not yet seen.
   list_request_type  request_q[$];
   list_response_type predicted_rsp_q[$];

   // Shadow of the list contents, owned by the checker block.
   data_type    list_slots[LIST_CAPACITY];
   int unsigned list_fill;

   int errors;
   int in_flight;     // accepted requests whose response has not been taken
   int n_checked;     // response transactions compared so far
   int cycles;

   // Generator-side length tracker, used only to steer positions and episode lengths.
   int unsigned gen_fill;
   int          n_random;

   always #5 clock = ~clock;

   // Apply one operation to the shadow list and return the response it must produce.
   function automatic list_response_type apply_list_op(input list_request_type req);
      list_response_type rsp;
      int unsigned       pos;
      rsp.read_value = '0;
      rsp.status     = STATUS_OK;
      pos            = req.position;
      case (req.operation)
         OP_INSERT: begin
            if (pos > list_fill) begin
               rsp.status = STATUS_RANGE;
            end else if (list_fill >= LIST_CAPACITY) begin
               rsp.status = STATUS_FULL;
            end else begin
               // Shift the tail back by one, then drop the new value into the hole.
               for (int i = list_fill; i > pos; i--) list_slots[i] = list_slots[i-1];
               list_slots[pos] = req.value;
               list_fill++;
            end
         end
         OP_REMOVE: begin
            if (pos >= list_fill) begin
               rsp.status = STATUS_RANGE;
            end else begin
               for (int i = pos; i + 1 < list_fill; i++) list_slots[i] = list_slots[i+1];
               list_fill--;
            end
         end
         OP_READ: begin
            if (pos >= list_fill) rsp.status = STATUS_RANGE;
            else                  rsp.read_value = list_slots[pos];
         end
         default: begin
            list_fill = 0;
         end
      endcase
      rsp.length = LEN_W'(list_fill);
      return rsp;
   endfunction

   // Queue one request and advance the generator's idea of the list length.
   task automatic queue_request(input logic [OP_W-1:0] op, input int unsigned pos,
                                input data_type val, input bit drain);
      list_request_type req;
      req.operation   = op;
      req.position    = POS_W'(pos);
      req.value       = val;
      req.drain_first = drain;
      request_q.push_back(req);
      n_random++;
      case (op)
         OP_INSERT: if (pos <= gen_fill && gen_fill < LIST_CAPACITY) gen_fill++;
         OP_REMOVE: if (pos < gen_fill) gen_fill--;
         OP_CLEAR:  gen_fill = 0;
         default:   ;
      endcase
   endtask

   // Mostly random words, with the sign and magnitude extremes mixed in.
   function automatic data_type pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return '0;
         default: return data_type'($urandom);
      endcase
   endfunction

   // Pick a position that the current length allows, or any 5-bit code now and then.
   function automatic int unsigned pick_position(input logic [OP_W-1:0] op);
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 31);
      if (op == OP_INSERT) return $urandom_range(0, gen_fill);
      if (gen_fill == 0)   return $urandom_range(0, 2);
      return $urandom_range(0, gen_fill - 1);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int unsigned    total;
      int unsigned    kind;
      int unsigned    roll;
      bit             drain;
      logic [OP_W-1:0] op;

      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_CLEAR;
      req_if.position  = '0;
      req_if.value     = '0;
      rsp_if.ready     = 1'b0;
      gen_fill         = 0;
      n_random         = 0;

      // Directed part: empty-list refusals, field extremes, ends of the list.
      queue_request(OP_CLEAR,  31, -32'sd1, 1'b0);
      queue_request(OP_READ,    0, '0, 1'b0);
      queue_request(OP_REMOVE,  0, '0, 1'b0);
      queue_request(OP_INSERT,  1, 32'sd5, 1'b0);          // past the end of an empty list
      queue_request(OP_INSERT,  0, 32'sh7fff_ffff, 1'b0);
      queue_request(OP_INSERT,  0, 32'sh8000_0000, 1'b0);  // at the head
      queue_request(OP_INSERT,  2, -32'sd1, 1'b0);         // at the tail
      queue_request(OP_INSERT,  1, '0, 1'b0);              // in the middle
      queue_request(OP_INSERT,  5, 32'sd9, 1'b0);          // one past the end
      queue_request(OP_READ,    0, 32'sd1, 1'b0);
      queue_request(OP_READ,    3, '0, 1'b0);
      queue_request(OP_READ,    4, '0, 1'b0);              // read at the length
      queue_request(OP_REMOVE,  3, '0, 1'b0);              // last entry
      queue_request(OP_REMOVE,  0, '0, 1'b0);              // first entry
      queue_request(OP_READ,   31, '0, 1'b0);
      queue_request(OP_REMOVE,  2, '0, 1'b0);              // remove at the length
      queue_request(OP_READ,    1, '0, 1'b0);
      queue_request(OP_CLEAR,  16, 32'sh8000_0000, 1'b0);

      // Random part: episodes that fill, drain, clear or stir the list.
      n_random = 0;
      while (n_random < RANDOM_REQUESTS) begin
         kind  = $urandom_range(0, 9);
         drain = (n_random == 0) || ($urandom_range(0, 3) == 0);
         if (kind <= 2) begin
            // Fill up, knock on the full list twice, then read the last entry.
            while (gen_fill < LIST_CAPACITY) begin
               queue_request(OP_INSERT, $urandom_range(0, gen_fill), pick_value(), drain);
               drain = 1'b0;
            end
            queue_request(OP_INSERT, LIST_CAPACITY, pick_value(), 1'b0);
            queue_request(OP_INSERT, $urandom_range(0, 31), pick_value(), 1'b0);
            queue_request(OP_READ, LIST_CAPACITY - 1, pick_value(), 1'b0);
         end else if (kind <= 4) begin
            // Drain to empty with reads sprinkled in, then remove once more.
            while (gen_fill > 0) begin
               if ($urandom_range(0, 2) == 0)
                  queue_request(OP_READ, $urandom_range(0, gen_fill - 1), pick_value(), drain);
               queue_request(OP_REMOVE, $urandom_range(0, gen_fill - 1), pick_value(), drain);
               drain = 1'b0;
            end
            queue_request(OP_REMOVE, pick_position(OP_REMOVE), pick_value(), 1'b0);
         end else if (kind == 5) begin
            queue_request(OP_CLEAR, $urandom_range(0, 31), pick_value(), drain);
         end else begin
            repeat (24) begin
               roll = $urandom_range(0, 99);
               if (roll < 40)      op = OP_INSERT;
               else if (roll < 65) op = OP_REMOVE;
               else if (roll < 96) op = OP_READ;
               else                op = OP_CLEAR;
               queue_request(op, pick_position(op), pick_value(), drain);
               drain = 1'b0;
            end
         end
      end

      total = request_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for every response, then let the output register settle.
      while (n_checked != total) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0 && predicted_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Request driver: random gaps, calm stretches, and a drain hold-off
   // ------------------------------------------------------------------
   int unsigned      tx_wait;
   bit               tx_calm;
   list_request_type tx_next;

   always @(posedge clock) begin
      bit took;
      bit offer;
      if (reset) begin
         req_if.valid <= 1'b0;
         tx_wait = 0;
         tx_calm = 1'b0;
      end else begin
         took  = req_if.valid && req_if.ready;
         offer = req_if.valid && !took;
         if (took) begin
            // Flip between gappy and back-to-back stretches now and then.
            if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
            tx_wait = tx_calm ? 0 : $urandom_range(0, 3);
         end
         if (!offer) begin
            if (tx_wait != 0) begin
               tx_wait--;
            end else if (request_q.size() != 0 &&
                         (!request_q[0].drain_first || (in_flight == 0 && !took))) begin
               // Load the next transaction; a drain request waits for an empty pipe.
               tx_next = request_q.pop_front();
               req_if.operation <= tx_next.operation;
               req_if.position  <= tx_next.position;
               req_if.value     <= tx_next.value;
               offer = 1'b1;
            end
         end
         req_if.valid <= offer;
      end
   end

   // ------------------------------------------------------------------
   // Response receiver: short random stalls plus one long hold-off
   // ------------------------------------------------------------------
   int unsigned rx_hold;
   int unsigned rx_taken;
   bit          rx_calm;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_hold  = 0;
         rx_taken = 0;
         rx_calm  = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rx_taken++;
            if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
            // Hold off long once so the core backs up and stalls its input.
            if (rx_taken == LONG_HOLD_AT) rx_hold = LONG_HOLD_CYCLES;
            else                          rx_hold = rx_calm ? 0 : $urandom_range(0, 3);
         end else if (rx_hold != 0) begin
            rx_hold--;
         end
         rsp_if.ready <= (rx_hold == 0);
      end
   end

   // ------------------------------------------------------------------
   // Checker: compare the oldest prediction first, then predict new requests
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      list_request_type  seen_req;
      list_response_type want;
      bit                acc;
      bit                got;
      if (reset) begin
         in_flight <= 0;
         n_checked <= 0;
         list_fill = 0;
      end else begin
         acc = req_if.valid && req_if.ready;
         got = rsp_if.valid && rsp_if.ready;
         if (got) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("response with nothing predicted: read_value %0d status %0d length %0d",
                      rsp_if.read_value, rsp_if.status, rsp_if.length);
               errors++;
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_if.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         rsp_if.read_value);
                  errors++;
               end
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  errors++;
               end
               if (rsp_if.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_if.length);
                  errors++;
               end
            end
            n_checked <= n_checked + 1;
         end
         if (acc) begin
            seen_req.operation   = req_if.operation;
            seen_req.position    = req_if.position;
            seen_req.value       = req_if.value;
            seen_req.drain_first = 1'b0;
            predicted_rsp_q.push_back(apply_list_op(seen_req));
         end
         in_flight <= in_flight + int'(acc) - int'(got);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if the core stops answering
   // ------------------------------------------------------------------
   initial begin
      errors = 0;
      cycles = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

`default_nettype wire

[files.f]
hdl/olpt_pkg.sv
hdl/olpt_channels.sv
hdl/olpt_ctrl.sv
hdl/olpt_datapath.sv
hdl/ordered_list_position_table_core.sv
tb/tb.sv
